// ===== sv/tlpm_pkg.sv =====
// Shared types, constants and the helper function of the tick latency percentile monitor.
package tlpm_pkg;

    localparam int WINDOW_DEPTH_DEF = 512;
    localparam int DELAY_BITS_DEF   = 32;

    localparam int NOW_BITS = 48;
    localparam int CFG_BITS = 16;
    localparam int IDX_BITS = 8;
    localparam int CNT_BITS = 32;
    localparam int OUT_BITS = 32;

    // Result transaction: nine 32-bit fields and the notify flag, padded to whole bytes.
    localparam int OUT_FIELDS    = 9;
    localparam int OUT_RAW_BITS  = OUT_FIELDS * OUT_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic [IDX_BITS-1:0] REG_INTERVAL   = 8'd0;
    localparam logic [IDX_BITS-1:0] REG_STALL_LOW  = 8'd1;
    localparam logic [IDX_BITS-1:0] REG_STALL_MID  = 8'd2;
    localparam logic [IDX_BITS-1:0] REG_STALL_HIGH = 8'd3;

    localparam logic [CFG_BITS-1:0] INTERVAL_MIN    = 16'd10;
    localparam logic [CFG_BITS-1:0] INTERVAL_RESET  = 16'd10;
    localparam logic [CFG_BITS-1:0] STALL_LOW_RESET = 16'd100;
    localparam logic [CFG_BITS-1:0] STALL_MID_RESET = 16'd500;
    localparam logic [CFG_BITS-1:0] STALL_HIGH_RST  = 16'd1000;

    localparam logic [NOW_BITS-1:0] NOW_MAX = {NOW_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    localparam logic [3:0] TEN_LAST = 4'd9;

    // The 95th percentile rank is tracked as quotient and remainder of (95n + 99) / 100.
    localparam logic [7:0] P95_NUM  = 8'd95;
    localparam logic [7:0] P95_DEN  = 8'd100;
    localparam logic [6:0] P95_BIAS = 7'd99;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_UPDATE,
        ST_START,
        ST_SELECT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic calc;
        logic update;
    } stats_ctrl_t;

    typedef struct packed {
        logic start;
    } rank_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rank_stat_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] tick_count;
        logic [OUT_BITS-1:0] last_delay;
        logic [OUT_BITS-1:0] max_delay;
        logic [OUT_BITS-1:0] stalls_low;
        logic [OUT_BITS-1:0] stalls_mid;
        logic [OUT_BITS-1:0] stalls_high;
        logic [OUT_BITS-1:0] stall_max;
        logic                notify;
    } stats_t;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// ===== sv/tlpm_cell.sv =====
// One window cell: holds a stored delay and takes its neighbour's value when the row moves.
module tlpm_cell #(
    parameter int DELAY_BITS = tlpm_pkg::DELAY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DELAY_BITS-1:0] d,
    output logic [DELAY_BITS-1:0] q
);

    logic [DELAY_BITS-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= d;
        end
    end

    assign q = value_reg;

endmodule

// ===== sv/tlpm_stats.sv =====
// Delay computation, running maxima and saturating tick and stall counters.
module tlpm_stats #(
    parameter int DELAY_BITS = tlpm_pkg::DELAY_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlpm_pkg::stats_ctrl_t           ctrl,
    input  logic [tlpm_pkg::NOW_BITS-1:0]   now,
    input  logic [tlpm_pkg::CFG_BITS-1:0]   interval,
    input  logic [tlpm_pkg::CFG_BITS-1:0]   stall_low,
    input  logic [tlpm_pkg::CFG_BITS-1:0]   stall_mid,
    input  logic [tlpm_pkg::CFG_BITS-1:0]   stall_high,
    output logic [DELAY_BITS-1:0]           delay,
    output tlpm_pkg::stats_t                stats
);

    localparam int NB = tlpm_pkg::NOW_BITS;
    localparam logic [NB-1:0] DELAY_MAX = (NB'(1) << DELAY_BITS) - NB'(1);
    localparam int CFG_W = tlpm_pkg::CFG_BITS;

    logic [NB-1:0]                   expected_reg, expected_next;
    logic [tlpm_pkg::CNT_BITS-1:0]   tick_total_reg, tick_total_next;
    logic [3:0]                      mod_ten_reg, mod_ten_next;
    logic [DELAY_BITS-1:0]           delay_reg, delay_next;
    logic [DELAY_BITS-1:0]           peak_reg, peak_next;
    logic [DELAY_BITS-1:0]           stall_peak_reg, stall_peak_next;
    logic [tlpm_pkg::CNT_BITS-1:0]   cnt_low_reg, cnt_low_next;
    logic [tlpm_pkg::CNT_BITS-1:0]   cnt_mid_reg, cnt_mid_next;
    logic [tlpm_pkg::CNT_BITS-1:0]   cnt_high_reg, cnt_high_next;

    logic [CFG_W-1:0] eff_interval;
    logic [NB:0]      diff;
    logic [NB:0]      sum;
    logic [NB-1:0]    diff_sat;
    logic             hit_low, hit_mid, hit_high;

    always_comb
    begin
        eff_interval = (interval < tlpm_pkg::INTERVAL_MIN) ? tlpm_pkg::INTERVAL_MIN : interval;
        diff = {1'b0, now} - {1'b0, expected_reg};
        sum  = {1'b0, now} + (NB + 1)'(eff_interval);
        if (diff[NB] || diff == '0)
        begin
            diff_sat = '0;
        end
        else if (diff[NB-1:0] > DELAY_MAX)
        begin
            diff_sat = DELAY_MAX;
        end
        else
        begin
            diff_sat = diff[NB-1:0];
        end

        hit_low  = delay_reg >= DELAY_BITS'(stall_low);
        hit_mid  = delay_reg >= DELAY_BITS'(stall_mid);
        hit_high = delay_reg >= DELAY_BITS'(stall_high);

        expected_next   = expected_reg;
        delay_next      = delay_reg;
        tick_total_next = tick_total_reg;
        mod_ten_next    = mod_ten_reg;
        peak_next       = peak_reg;
        stall_peak_next = stall_peak_reg;
        cnt_low_next    = cnt_low_reg;
        cnt_mid_next    = cnt_mid_reg;
        cnt_high_next   = cnt_high_reg;

        if (ctrl.calc)
        begin
            delay_next    = diff_sat[DELAY_BITS-1:0];
            expected_next = sum[NB] ? tlpm_pkg::NOW_MAX : sum[NB-1:0];
        end

        if (ctrl.update)
        begin
            tick_total_next = tlpm_pkg::sat_inc(tick_total_reg);
            mod_ten_next    = (mod_ten_reg >= tlpm_pkg::TEN_LAST) ? 4'd0 : mod_ten_reg + 4'd1;
            if (delay_reg > peak_reg)
            begin
                peak_next = delay_reg;
            end
            if (hit_low)
            begin
                cnt_low_next = tlpm_pkg::sat_inc(cnt_low_reg);
                if (delay_reg > stall_peak_reg)
                begin
                    stall_peak_next = delay_reg;
                end
            end
            if (hit_mid)
            begin
                cnt_mid_next = tlpm_pkg::sat_inc(cnt_mid_reg);
            end
            if (hit_high)
            begin
                cnt_high_next = tlpm_pkg::sat_inc(cnt_high_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg   <= NB'(tlpm_pkg::INTERVAL_RESET);
            tick_total_reg <= '0;
            mod_ten_reg    <= '0;
            delay_reg      <= '0;
            peak_reg       <= '0;
            stall_peak_reg <= '0;
            cnt_low_reg    <= '0;
            cnt_mid_reg    <= '0;
            cnt_high_reg   <= '0;
        end
        else
        begin
            expected_reg   <= expected_next;
            tick_total_reg <= tick_total_next;
            mod_ten_reg    <= mod_ten_next;
            delay_reg      <= delay_next;
            peak_reg       <= peak_next;
            stall_peak_reg <= stall_peak_next;
            cnt_low_reg    <= cnt_low_next;
            cnt_mid_reg    <= cnt_mid_next;
            cnt_high_reg   <= cnt_high_next;
        end
    end

    assign delay = delay_reg;

    always_comb
    begin
        stats.tick_count   = tick_total_reg;
        stats.last_delay   = tlpm_pkg::OUT_BITS'(delay_reg);
        stats.max_delay    = tlpm_pkg::OUT_BITS'(peak_reg);
        stats.stalls_low   = cnt_low_reg;
        stats.stalls_mid   = cnt_mid_reg;
        stats.stalls_high  = cnt_high_reg;
        stats.stall_max    = tlpm_pkg::OUT_BITS'(stall_peak_reg);
        stats.notify       = (mod_ten_reg == 4'd0) || hit_low;
    end

endmodule

// ===== sv/tlpm_rank.sv =====
// Bitwise rank selection: finds two order statistics as the window row rotates past its head.
module tlpm_rank #(
    parameter int WINDOW_DEPTH = tlpm_pkg::WINDOW_DEPTH_DEF,
    parameter int DELAY_BITS   = tlpm_pkg::DELAY_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tlpm_pkg::rank_ctrl_t                  ctrl,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0]     fill,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]       k50,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]       k95,
    input  logic [DELAY_BITS-1:0]                 head,
    output tlpm_pkg::rank_stat_t                  stat,
    output logic [DELAY_BITS-1:0]                 p50,
    output logic [DELAY_BITS-1:0]                 p95
);

    localparam int IDXW = $clog2(WINDOW_DEPTH);
    localparam int CNTW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [IDXW-1:0] POS_LAST = IDXW'(WINDOW_DEPTH - 1);

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [IDXW-1:0]       pos_reg, pos_next;
    logic [IDXW-1:0]       skip_reg, skip_next;
    logic [DELAY_BITS-1:0] sel_reg, sel_next;
    logic [DELAY_BITS-1:0] mask_reg, mask_next;
    logic [DELAY_BITS-1:0] pfx50_reg, pfx50_next;
    logic [DELAY_BITS-1:0] pfx95_reg, pfx95_next;
    logic [IDXW-1:0]       rem50_reg, rem50_next;
    logic [IDXW-1:0]       rem95_reg, rem95_next;
    logic [CNTW-1:0]       cnt50_reg, cnt50_next;
    logic [CNTW-1:0]       cnt95_reg, cnt95_next;

    logic            in_win, bit_zero, hit50, hit95, last_pos;
    logic [CNTW-1:0] sum50, sum95;

    always_comb
    begin
        // The row holds the newest delay in cell 0, so the valid entries reach the head last.
        in_win   = pos_reg >= skip_reg;
        bit_zero = (head & sel_reg) == '0;
        hit50    = in_win && bit_zero && (((head ^ pfx50_reg) & mask_reg) == '0);
        hit95    = in_win && bit_zero && (((head ^ pfx95_reg) & mask_reg) == '0);
        sum50    = cnt50_reg + CNTW'(hit50);
        sum95    = cnt95_reg + CNTW'(hit95);
        last_pos = pos_reg == POS_LAST;

        active_next = active_reg;
        done_next   = 1'b0;
        pos_next    = pos_reg;
        skip_next   = skip_reg;
        sel_next    = sel_reg;
        mask_next   = mask_reg;
        pfx50_next  = pfx50_reg;
        pfx95_next  = pfx95_reg;
        rem50_next  = rem50_reg;
        rem95_next  = rem95_reg;
        cnt50_next  = cnt50_reg;
        cnt95_next  = cnt95_reg;

        if (ctrl.start)
        begin
            active_next = 1'b1;
            pos_next    = '0;
            skip_next   = IDXW'(CNTW'(WINDOW_DEPTH) - fill);
            sel_next    = {1'b1, {(DELAY_BITS-1){1'b0}}};
            mask_next   = '0;
            pfx50_next  = '0;
            pfx95_next  = '0;
            rem50_next  = k50;
            rem95_next  = k95;
            cnt50_next  = '0;
            cnt95_next  = '0;
        end
        else if (active_reg)
        begin
            cnt50_next = sum50;
            cnt95_next = sum95;
            pos_next   = last_pos ? '0 : pos_reg + 1'b1;
            if (last_pos)
            begin
                // End of a pass: no more zeros than the remaining rank means the bit is one.
                if (CNTW'(rem50_reg) >= sum50)
                begin
                    pfx50_next = pfx50_reg | sel_reg;
                    rem50_next = rem50_reg - IDXW'(sum50);
                end
                if (CNTW'(rem95_reg) >= sum95)
                begin
                    pfx95_next = pfx95_reg | sel_reg;
                    rem95_next = rem95_reg - IDXW'(sum95);
                end
                cnt50_next = '0;
                cnt95_next = '0;
                sel_next   = sel_reg >> 1;
                mask_next  = {1'b1, mask_reg[DELAY_BITS-1:1]};
                if (sel_reg[0])
                begin
                    active_next = 1'b0;
                    done_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        skip_reg  <= skip_next;
        sel_reg   <= sel_next;
        mask_reg  <= mask_next;
        pfx50_reg <= pfx50_next;
        pfx95_reg <= pfx95_next;
        rem50_reg <= rem50_next;
        rem95_reg <= rem95_next;
        cnt50_reg <= cnt50_next;
        cnt95_reg <= cnt95_next;
    end

    assign stat.busy = active_reg;
    assign stat.done = done_reg;
    assign p50       = pfx50_reg;
    assign p95       = pfx95_reg;

`ifndef NO_ASSERTIONS
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> $onehot(sel_reg))
        else $error("bit selector is not one-hot during selection");

    a_done_after_active: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(active_reg) && !active_reg)
        else $error("selection finished without a running pass");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> active_reg && pos_reg == '0)
        else $error("selection did not start at the first position");
`endif

endmodule

// ===== sv/tick_latency_percentile_monitor.sv =====
// Top level of the tick latency percentile monitor: registers, control and result stage.
//
// Each tick transaction on s_axis carries a millisecond timestamp. The block works out the
// tick's delay against the expected time, updates saturating tick and stall counters and the
// running maxima, and shifts the delay into a row of WINDOW_DEPTH cells that holds the most
// recent delays. The median and 95th percentile (nearest rank) are then found one bit at a
// time: for each of the DELAY_BITS bits the cell row rotates once past a counter at its head,
// and the tick's result appears on m_axis after the last pass. One tick is processed at a
// time; a finished result waits in the output register while the next tick is accepted.
// Configuration writes are taken in every cycle and should only be made while no tick is in
// flight.
module tick_latency_percentile_monitor #(
    parameter int WINDOW_DEPTH = tlpm_pkg::WINDOW_DEPTH_DEF,
    parameter int DELAY_BITS   = tlpm_pkg::DELAY_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tlpm_pkg::IDX_BITS-1:0]         cfg_index,
    input  logic [tlpm_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // now_ms[47:0]
    input  logic [tlpm_pkg::NOW_BITS-1:0]         s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tick_count[31:0], last_delay[63:32], max_delay[95:64], median_delay[127:96],
    // p95_delay[159:128], stalls_low[191:160], stalls_mid[223:192], stalls_high[255:224],
    // stall_max[287:256], notify[288], zero padding[295:289]
    output logic [tlpm_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);

    localparam int IDXW = $clog2(WINDOW_DEPTH);
    localparam int CNTW = $clog2(WINDOW_DEPTH + 1);
    localparam int CW   = tlpm_pkg::CFG_BITS;
    localparam int OW   = tlpm_pkg::OUT_BITS;

    tlpm_pkg::state_t state_reg, state_next;

    logic [CW-1:0] interval_reg, stall_low_reg, stall_mid_reg, stall_high_reg;
    logic [tlpm_pkg::NOW_BITS-1:0] now_reg;

    logic [CNTW-1:0] fill_reg, fill_next;
    logic [CNTW-1:0] q95_reg, q95_next;
    logic [6:0]      r95_reg, r95_next;

    logic                                out_valid_reg, out_valid_next;
    logic [tlpm_pkg::OUT_DATA_BITS-1:0]  out_data_reg, out_data_next;

    tlpm_pkg::stats_ctrl_t stats_ctrl;
    tlpm_pkg::rank_ctrl_t  rank_ctrl;
    tlpm_pkg::rank_stat_t  rank_stat;
    tlpm_pkg::stats_t      stats;

    logic [DELAY_BITS-1:0] delay;
    logic [DELAY_BITS-1:0] p50, p95;
    logic [IDXW-1:0]       k50, k95;
    logic [CNTW:0]         half;
    logic [7:0]            r95_sum;
    logic                  insert, rotate, accept_in;

    logic [DELAY_BITS-1:0] cell_d [WINDOW_DEPTH];
    logic [DELAY_BITS-1:0] cell_q [WINDOW_DEPTH];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= tlpm_pkg::INTERVAL_RESET;
            stall_low_reg  <= tlpm_pkg::STALL_LOW_RESET;
            stall_mid_reg  <= tlpm_pkg::STALL_MID_RESET;
            stall_high_reg <= tlpm_pkg::STALL_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tlpm_pkg::REG_INTERVAL:   interval_reg   <= cfg_data;
                tlpm_pkg::REG_STALL_LOW:  stall_low_reg  <= cfg_data;
                tlpm_pkg::REG_STALL_MID:  stall_mid_reg  <= cfg_data;
                tlpm_pkg::REG_STALL_HIGH: stall_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = state_reg == tlpm_pkg::ST_IDLE;
    assign accept_in     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            now_reg <= s_axis_tdata;
        end
    end

    // Ranks for the selection: (n + 1) / 2 - 1 and ceil(0.95 n) - 1.
    always_comb
    begin
        half = ({1'b0, fill_reg} + (CNTW + 1)'(1)) >> 1;
        k50  = IDXW'(half - (CNTW + 1)'(1));
        k95  = IDXW'(q95_reg - CNTW'(1));
    end

    always_comb
    begin
        state_next        = state_reg;
        stats_ctrl.calc   = 1'b0;
        stats_ctrl.update = 1'b0;
        rank_ctrl.start   = 1'b0;
        insert            = 1'b0;
        fill_next         = fill_reg;
        q95_next          = q95_reg;
        r95_next          = r95_reg;
        r95_sum           = {1'b0, r95_reg} + tlpm_pkg::P95_NUM;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_data_next     = out_data_reg;

        case (state_reg)
            tlpm_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = tlpm_pkg::ST_CALC;
                end
            end
            tlpm_pkg::ST_CALC:
            begin
                stats_ctrl.calc = 1'b1;
                state_next      = tlpm_pkg::ST_UPDATE;
            end
            tlpm_pkg::ST_UPDATE:
            begin
                stats_ctrl.update = 1'b1;
                insert            = 1'b1;
                if (fill_reg < CNTW'(WINDOW_DEPTH))
                begin
                    fill_next = fill_reg + 1'b1;
                    if (r95_sum >= tlpm_pkg::P95_DEN)
                    begin
                        r95_next = 7'(r95_sum - tlpm_pkg::P95_DEN);
                        q95_next = q95_reg + 1'b1;
                    end
                    else
                    begin
                        r95_next = r95_sum[6:0];
                    end
                end
                state_next = tlpm_pkg::ST_START;
            end
            tlpm_pkg::ST_START:
            begin
                rank_ctrl.start = 1'b1;
                state_next      = tlpm_pkg::ST_SELECT;
            end
            tlpm_pkg::ST_SELECT:
            begin
                if (rank_stat.done)
                begin
                    state_next = tlpm_pkg::ST_DONE;
                end
            end
            tlpm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {
                        {(tlpm_pkg::OUT_DATA_BITS - tlpm_pkg::OUT_RAW_BITS){1'b0}},
                        stats.notify,
                        stats.stall_max,
                        stats.stalls_high,
                        stats.stalls_mid,
                        stats.stalls_low,
                        OW'(p95),
                        OW'(p50),
                        stats.max_delay,
                        stats.last_delay,
                        stats.tick_count
                    };
                    state_next = tlpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlpm_pkg::ST_IDLE;
            fill_reg      <= '0;
            q95_reg       <= '0;
            r95_reg       <= tlpm_pkg::P95_BIAS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            q95_reg       <= q95_next;
            r95_reg       <= r95_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    tlpm_stats #(
        .DELAY_BITS (DELAY_BITS)
    ) u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stats_ctrl),
        .now        (now_reg),
        .interval   (interval_reg),
        .stall_low  (stall_low_reg),
        .stall_mid  (stall_mid_reg),
        .stall_high (stall_high_reg),
        .delay      (delay),
        .stats      (stats)
    );

    // Window row: a new delay enters cell 0 and the oldest drops off the far end; during
    // selection the far end feeds back into cell 0 so the row turns once per pass.
    assign rotate = rank_stat.busy;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign cell_d[gi] = insert ? delay : cell_q[WINDOW_DEPTH-1];
            end
            else
            begin : g_rest
                assign cell_d[gi] = cell_q[gi-1];
            end

            tlpm_cell #(
                .DELAY_BITS (DELAY_BITS)
            ) u_cell (
                .clk (clk),
                .en  (insert || rotate),
                .d   (cell_d[gi]),
                .q   (cell_q[gi])
            );
        end
    endgenerate

    tlpm_rank #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .DELAY_BITS   (DELAY_BITS)
    ) u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rank_ctrl),
        .fill  (fill_reg),
        .k50   (k50),
        .k95   (k95),
        .head  (cell_q[WINDOW_DEPTH-1]),
        .stat  (rank_stat),
        .p50   (p50),
        .p95   (p95)
    );

`ifndef NO_ASSERTIONS
    a_done_in_select: assert property (@(posedge clk) disable iff (!rst_n)
        rank_stat.done |-> state_reg == tlpm_pkg::ST_SELECT)
        else $error("selection result arrived outside the selection state");

    a_no_insert_while_rotating: assert property (@(posedge clk) disable iff (!rst_n)
        rank_stat.busy |-> !insert && state_reg == tlpm_pkg::ST_SELECT)
        else $error("window row written while it is rotating");
`endif

endmodule
